@@ hw/rtl/ptd_pkg.sv @@
// ============================================================================
// ptd_pkg: shared definitions for the trial-division primality tester
// Holds the default value width, the sequencer states and the status
// bundle that each arithmetic unit reports to the sequencer.
// ============================================================================
package ptd_pkg;

    // Default width of the value under test.
    localparam int DATA_BITS_DEFAULT = 31;

    // Width of the result beat's tdata (is_prime in bit 0, zero filled).
    localparam int OUT_TDATA_BITS = 8;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_CHECK,
        ST_ISSUE,
        ST_DIV,
        ST_FINISH
    } ptd_state_t;

    // Status reported by an iterative unit.
    typedef struct packed {
        logic busy;
        logic done;
    } ptd_unit_status_t;

endpackage

@@ hw/rtl/ptd_isqrt.sv @@
// ============================================================================
// ptd_isqrt: iterative integer square root
// Digit-by-digit restoring square root, one root bit per cycle. The floor
// of the root is valid on root when status.done pulses.
// ============================================================================
module ptd_isqrt #(
    parameter int DATA_BITS = ptd_pkg::DATA_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DATA_BITS-1:0]          operand,
    output logic [(DATA_BITS+1)/2-1:0]    root,
    output ptd_pkg::ptd_unit_status_t     status
);

    localparam int RootBits = (DATA_BITS + 1) / 2;
    localparam int PadBits  = 2 * RootBits;
    localparam int RemBits  = RootBits + 2;
    localparam int CntBits  = $clog2(RootBits + 1);

    logic [PadBits-1:0]  rad_reg,  rad_next;
    logic [RemBits-1:0]  rem_reg,  rem_next;
    logic [RootBits-1:0] root_reg, root_next;
    logic [CntBits-1:0]  cnt_reg,  cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [RemBits-1:0]  rem_shift;
    logic [RemBits-1:0]  trial;

    // One step: bring down two radicand bits and try the next root bit.
    assign rem_shift = {rem_reg[RemBits-3:0], rad_reg[PadBits-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = PadBits'(operand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CntBits'(RootBits);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[PadBits-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[RootBits-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[RootBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath needs none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ hw/rtl/ptd_rem.sv @@
// ============================================================================
// ptd_rem: iterative remainder unit
// Restoring shift-subtract division, one dividend bit per cycle. Reports
// whether the divisor divides the dividend exactly when status.done pulses.
// ============================================================================
module ptd_rem #(
    parameter int DATA_BITS = ptd_pkg::DATA_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DATA_BITS-1:0]          dividend,
    input  logic [(DATA_BITS+1)/2-1:0]    divisor,
    output logic                          exact,
    output ptd_pkg::ptd_unit_status_t     status
);

    localparam int RootBits = (DATA_BITS + 1) / 2;
    localparam int RemBits  = RootBits + 1;
    localparam int CntBits  = $clog2(DATA_BITS + 1);

    logic [DATA_BITS-1:0] num_reg,  num_next;
    logic [RootBits-1:0]  den_reg,  den_next;
    logic [RemBits-1:0]   rem_reg,  rem_next;
    logic [CntBits-1:0]   cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [RemBits-1:0]   rem_shift;

    // Partial remainder stays below the divisor, so the shifted value fits.
    assign rem_shift = {rem_reg[RootBits-1:0], num_reg[DATA_BITS-1]};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = CntBits'(DATA_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[DATA_BITS-2:0], 1'b0};
            if (rem_shift >= {1'b0, den_reg}) begin
                rem_next = rem_shift - {1'b0, den_reg};
            end else begin
                rem_next = rem_shift;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign exact       = (rem_reg == '0);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ hw/rtl/prime_test_trial_division.sv @@
// ============================================================================
// prime_test_trial_division: primality test by trial division
// Takes one value per input beat and returns one beat saying whether the
// value is prime.
// ============================================================================
// Usage:
//   Input beats arrive on s_axis_* with the value in the low DATA_BITS bits
//   of tdata; higher tdata bits are ignored. Each input beat yields exactly
//   one result beat on m_axis_* with is_prime in tdata bit 0.
//   The block works on one value at a time: s_axis_tready is high only
//   while the sequencer is idle.
//   The square root runs first; then the remainder unit is started once
//   for each trial divisor from 2 up to the floor of the root, stopping
//   at the first exact divisor. Values 0 to 3 finish after the root.
//   With the default width a large prime tries about 46340 divisors;
//   the bit-serial remainder unit dominates its run time.
//   The result sits in an output register, so the next value is accepted
//   while a result waits. If the receiver stalls and a second result is
//   ready, the sequencer holds it until the output register frees up.
//   Reset (aresetn low, synchronous) returns the sequencer to idle and
//   drops any pending result.
// ============================================================================
module prime_test_trial_division #(
    parameter int DATA_BITS = ptd_pkg::DATA_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata fields from bit 0: value [DATA_BITS-1:0], zero fill.
    input  logic [((DATA_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0: is_prime [0], zero fill.
    output logic [ptd_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready
);

    localparam int RootBits = (DATA_BITS + 1) / 2;

    ptd_pkg::ptd_state_t state_reg, state_next;

    logic [DATA_BITS-1:0] value_reg, value_next;
    logic [RootBits-1:0]  root_reg,  root_next;
    logic [RootBits-1:0]  div_reg,   div_next;
    logic                 verdict_reg, verdict_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_prime_reg, out_prime_next;

    logic                 in_beat;
    logic                 sqrt_start;
    logic                 rem_start;
    logic                 out_load;
    logic                 out_free;

    logic [RootBits-1:0]  sqrt_root;
    logic                 rem_exact;
    ptd_pkg::ptd_unit_status_t sqrt_status;
    ptd_pkg::ptd_unit_status_t rem_status;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Square root unit, started by the input beat.
    ptd_isqrt #(
        .DATA_BITS (DATA_BITS)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (s_axis_tdata[DATA_BITS-1:0]),
        .root    (sqrt_root),
        .status  (sqrt_status)
    );

    // Remainder unit, reused for every trial divisor.
    ptd_rem #(
        .DATA_BITS (DATA_BITS)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (value_reg),
        .divisor  (div_reg),
        .exact    (rem_exact),
        .status   (rem_status)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptd_pkg::ST_IDLE: begin
                if (in_beat) begin
                    state_next = ptd_pkg::ST_ROOT;
                end
            end
            ptd_pkg::ST_ROOT: begin
                if (sqrt_status.done) begin
                    state_next = ptd_pkg::ST_CHECK;
                end
            end
            ptd_pkg::ST_CHECK: begin
                if (value_reg < DATA_BITS'(2) || root_reg < RootBits'(2)) begin
                    state_next = ptd_pkg::ST_FINISH;
                end else begin
                    state_next = ptd_pkg::ST_ISSUE;
                end
            end
            ptd_pkg::ST_ISSUE: begin
                state_next = ptd_pkg::ST_DIV;
            end
            ptd_pkg::ST_DIV: begin
                if (rem_status.done) begin
                    if (rem_exact || div_reg == root_reg) begin
                        state_next = ptd_pkg::ST_FINISH;
                    end else begin
                        state_next = ptd_pkg::ST_ISSUE;
                    end
                end
            end
            ptd_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = ptd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        sqrt_start    = 1'b0;
        rem_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ptd_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                sqrt_start    = s_axis_tvalid;
            end
            ptd_pkg::ST_ISSUE: begin
                rem_start = 1'b1;
            end
            ptd_pkg::ST_FINISH: begin
                out_load = out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Datapath registers: value, root, current divisor and verdict.
    always_comb begin
        value_next   = value_reg;
        root_next    = root_reg;
        div_next     = div_reg;
        verdict_next = verdict_reg;
        case (state_reg)
            ptd_pkg::ST_IDLE: begin
                if (in_beat) begin
                    value_next = s_axis_tdata[DATA_BITS-1:0];
                end
            end
            ptd_pkg::ST_ROOT: begin
                if (sqrt_status.done) begin
                    root_next = sqrt_root;
                end
            end
            ptd_pkg::ST_CHECK: begin
                // Zero and one are not prime; two and three have no divisor.
                verdict_next = (value_reg >= DATA_BITS'(2));
                div_next     = RootBits'(2);
            end
            ptd_pkg::ST_DIV: begin
                if (rem_status.done) begin
                    if (rem_exact) begin
                        verdict_next = 1'b0;
                    end else if (div_reg == root_reg) begin
                        verdict_next = 1'b1;
                    end else begin
                        div_next = div_reg + 1'b1;
                    end
                end
            end
            default: begin
                verdict_next = verdict_reg;
            end
        endcase
    end

    // Output register: loaded once per item, cleared when the beat is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_prime_next = verdict_reg;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ptd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg     <= value_next;
        root_reg      <= root_next;
        div_reg       <= div_next;
        verdict_reg   <= verdict_next;
        out_prime_reg <= out_prime_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(ptd_pkg::OUT_TDATA_BITS-1){1'b0}}, out_prime_reg};

`ifndef NO_ASSERTIONS
    // Neither unit runs while the sequencer waits for a new value.
    a_idle_units_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ptd_pkg::ST_IDLE |-> !sqrt_status.busy && !rem_status.busy)
        else $error("arithmetic unit busy while sequencer idle");

    // A trial divisor always lies between two and the root.
    a_div_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ptd_pkg::ST_DIV |-> div_reg >= RootBits'(2) && div_reg <= root_reg)
        else $error("trial divisor out of range");

    // After an input beat no further beat is taken until a result is made.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // The output register is only loaded when it is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result overwrote a pending beat");
`endif

endmodule

@@ verif/tb_prime_test_trial_division.sv @@
// ============================================================================
// tb_prime_test_trial_division: self-checking bench for the primality tester
// A queue of values is streamed into the block with random gaps. Every
// accepted beat gets its verdict predicted by plain trial division.
// Result beats are checked in order against those verdicts while the
// receiver stalls at random. The run includes one long receiver hold-off
// and one point where the sender drains the block completely.
// ============================================================================
module tb_prime_test_trial_division;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS       = ptd_pkg::DATA_BITS_DEFAULT;
    localparam int OUT_TDATA_BITS   = ptd_pkg::OUT_TDATA_BITS;
    localparam int IN_TDATA_BITS    = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DIRECTED_ITEMS   = 22;
    localparam int RANDOM_ITEMS     = 78;
    // The first random values are tiny so the long hold-off fills the block fast.
    localparam int TINY_ITEMS       = 30;
    localparam int LONG_HOLD_AFTER  = DIRECTED_ITEMS + 5;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int DRAIN_AT         = DIRECTED_ITEMS + 60;
    localparam int SETTLE_CYCLES    = 64;

    // One accepted value and the verdict predicted for it.
    typedef struct {
        logic [IN_TDATA_BITS-1:0] word;
        bit                       is_prime;
    } verdict_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic [IN_TDATA_BITS-1:0]      s_axis_tdata  = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [OUT_TDATA_BITS-1:0]     m_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;

    logic [IN_TDATA_BITS-1:0] pending_words [$];
    verdict_t                 pending_verdicts [$];
    verdict_t                 oldest_verdict;
    int                       beats_sent     = 0;
    int                       results_seen   = 0;
    int                       send_gap       = 0;
    int                       stall_left     = 0;
    int                       receive_gap;
    bit                       long_hold_done = 1'b0;
    int                       mismatches     = 0;

    prime_test_trial_division DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // Free-running 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Trial division up to the integer square root; 0 and 1 are not prime.
    function automatic bit predict_is_prime(input logic [VALUE_BITS-1:0] value);
        longint unsigned n;
        longint unsigned d;
        n = value;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] error: %s", $time, what);
    endtask

    // Input driver: offers queued words, records each accepted beat.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                pending_verdicts.push_back('{word: s_axis_tdata,
                    is_prime: predict_is_prime(s_axis_tdata[VALUE_BITS-1:0])});
            end
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() == 0 ||
                         (beats_sent == DRAIN_AT && pending_verdicts.size() != 0)) begin
                // Out of words, or pausing until the block has drained.
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_words.pop_front();
                beats_sent    <= beats_sent + 1;
                send_gap      <= pick_gap();
            end
        end
    end

    // Result monitor: checks each beat in order.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result beat 0x%0h with nothing expected",
                    m_axis_tdata));
            end else begin
                oldest_verdict = pending_verdicts.pop_front();
                if (m_axis_tdata !== OUT_TDATA_BITS'(oldest_verdict.is_prime)) begin
                    report_mismatch($sformatf(
                        "value %0d (beat 0x%0h): is_prime got 0x%0h, want %0d",
                        oldest_verdict.word[VALUE_BITS-1:0], oldest_verdict.word,
                        m_axis_tdata, oldest_verdict.is_prime));
                end
            end
        end
    end

    // Receiver stalls: random gaps after beats and one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            // One long hold-off lets the block fill up and stall its input.
            if (!long_hold_done && results_seen == LONG_HOLD_AFTER) begin
                long_hold_done <= 1'b1;
                stall_left     <= LONG_HOLD_CYCLES;
                m_axis_tready  <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                receive_gap = pick_gap();
                if (receive_gap > 0) begin
                    stall_left    <= receive_gap - 1;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [IN_TDATA_BITS-1:0] directed_words [0:DIRECTED_ITEMS-1];
        logic [IN_TDATA_BITS-1:0] value;
        int                       roll;
        int                       factor;
        int                       n;

        // Zero, one, two and three; small squares of primes; small primes and
        // composites; a perfect square whose only factor is the root itself;
        // values around 2^16; the largest value, which is prime; and words with
        // the fill bit above the value set, which the block must ignore.
        directed_words = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15,
            32'd17, 32'd25, 32'd49, 32'd97, 32'd121, 32'd169,
            32'd1042441, 32'd65521, 32'd65537, 32'h4000_0000,
            32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0003, 32'hFFFF_FFFE
        };
        for (n = 0; n < DIRECTED_ITEMS; n++) begin
            pending_words.push_back(directed_words[n]);
        end

        // Mostly small values; a few wide ones, kept composite with a small
        // factor so that they finish quickly.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (n < TINY_ITEMS || roll < 60) begin
                value = $urandom_range(0, 1023);
            end else if (roll < 75) begin
                value = $urandom_range(1024, 65535);
            end else if (roll < 88) begin
                value = $urandom_range(65536, 1 << 20);
            end else begin
                value  = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
                factor = $urandom_range(2, 7);
                value  = value - value % factor;
            end
            value[IN_TDATA_BITS-1] = ($urandom_range(0, 3) == 0);
            pending_words.push_back(value);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(negedge aclk);
        end while (pending_words.size() != 0 || s_axis_tvalid ||
                   pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (pending_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived",
                pending_verdicts.size()));
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: ends the run as a mismatch if it has not finished; the largest prime is the slowest item.
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
